// ===== rtl/simplified_aes_cipher_defines.svh =====
// Assertion macros used by the cipher RTL.
`ifndef SIMPLIFIED_AES_CIPHER_DEFINES_SVH
`define SIMPLIFIED_AES_CIPHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAES_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("saes: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SAES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("saes: next-cycle check failed");

`endif

// ===== rtl/saes_pkg.sv =====
`timescale 1ns / 1ps

package saes_pkg;

    localparam int unsigned BLOCK_W = 16;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned WORD_W  = 8;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [WORD_W-1:0] RCON_ONE = 8'h80;
    localparam logic [WORD_W-1:0] RCON_TWO = 8'h30;

    // MixColumn and its inverse, as diagonal / off-diagonal factors
    localparam logic [NIB_W-1:0] MIX_DIAG     = 4'h1;
    localparam logic [NIB_W-1:0] MIX_OFF      = 4'h4;
    localparam logic [NIB_W-1:0] INV_MIX_DIAG = 4'h9;
    localparam logic [NIB_W-1:0] INV_MIX_OFF  = 4'h2;

    localparam logic [NIB_W-1:0] FWD_SBOX [0:15] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };
    localparam logic [NIB_W-1:0] INV_SBOX [0:15] = '{
        4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
        4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
    };

    typedef struct packed {
        logic [BLOCK_W-1:0] k0;
        logic [BLOCK_W-1:0] k1;
        logic [BLOCK_W-1:0] k2;
    } round_keys_t;

    // GF(16) product modulo x^4 + x + 1
    function automatic logic [NIB_W-1:0] gf16_mul(input logic [NIB_W-1:0] a,
                                                   input logic [NIB_W-1:0] b);
        logic [NIB_W-1:0] acc;
        logic [NIB_W-1:0] aa;
        acc = '0;
        aa  = a;
        for (int i = 0; i < NIB_W; i++) begin
            if (b[i]) begin
                acc = acc ^ aa;
            end
            aa = {aa[NIB_W-2:0], 1'b0} ^ (aa[NIB_W-1] ? 4'h3 : 4'h0);
        end
        return acc;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_nib_fwd(input logic [BLOCK_W-1:0] v);
        return {FWD_SBOX[v[15:12]], FWD_SBOX[v[11:8]], FWD_SBOX[v[7:4]], FWD_SBOX[v[3:0]]};
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_nib_inv(input logic [BLOCK_W-1:0] v);
        return {INV_SBOX[v[15:12]], INV_SBOX[v[11:8]], INV_SBOX[v[7:4]], INV_SBOX[v[3:0]]};
    endfunction

    // swap the second nibbles of the two columns
    function automatic logic [BLOCK_W-1:0] shift_row(input logic [BLOCK_W-1:0] v);
        return {v[15:12], v[3:0], v[7:4], v[11:8]};
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] v,
                                                    input logic [NIB_W-1:0] diag,
                                                    input logic [NIB_W-1:0] off);
        logic [NIB_W-1:0] a2;
        logic [NIB_W-1:0] b2;
        logic [NIB_W-1:0] c2;
        logic [NIB_W-1:0] d2;
        a2 = gf16_mul(diag, v[15:12]) ^ gf16_mul(off, v[11:8]);
        b2 = gf16_mul(off, v[15:12]) ^ gf16_mul(diag, v[11:8]);
        c2 = gf16_mul(diag, v[7:4]) ^ gf16_mul(off, v[3:0]);
        d2 = gf16_mul(off, v[7:4]) ^ gf16_mul(diag, v[3:0]);
        return {a2, b2, c2, d2};
    endfunction

    // rotate the word by one nibble, then substitute both nibbles
    function automatic logic [WORD_W-1:0] word_g(input logic [WORD_W-1:0] w);
        return {FWD_SBOX[w[3:0]], FWD_SBOX[w[7:4]]};
    endfunction

    function automatic round_keys_t expand_key(input logic [BLOCK_W-1:0] key);
        round_keys_t      rk;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w4;
        logic [WORD_W-1:0] w5;
        w2 = key[15:8] ^ RCON_ONE ^ word_g(key[7:0]);
        w3 = w2 ^ key[7:0];
        w4 = w2 ^ RCON_TWO ^ word_g(w3);
        w5 = w4 ^ w3;
        rk.k0 = key;
        rk.k1 = {w2, w3};
        rk.k2 = {w4, w5};
        return rk;
    endfunction

endpackage

// ===== rtl/saes_key_sched.sv =====
`timescale 1ns / 1ps

module saes_key_sched (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [saes_pkg::BLOCK_W-1:0]     cfg_wdata,
    output saes_pkg::round_keys_t            round_keys
);

    saes_pkg::round_keys_t keys_reg;
    saes_pkg::round_keys_t keys_next;

    // expand once per key write so the data path sees ready round keys
    always_comb begin
        keys_next = keys_reg;
        if (cfg_we) begin
            keys_next = saes_pkg::expand_key(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= saes_pkg::expand_key('0);
        end else begin
            keys_reg <= keys_next;
        end
    end

    assign round_keys = keys_reg;

endmodule

// ===== rtl/saes_core.sv =====
`timescale 1ns / 1ps

module saes_core (
    input  logic                             operation,
    input  logic [saes_pkg::BLOCK_W-1:0]     data_block,
    input  saes_pkg::round_keys_t            round_keys,
    output logic [saes_pkg::BLOCK_W-1:0]     result_block
);

    logic [saes_pkg::BLOCK_W-1:0] enc_r1;
    logic [saes_pkg::BLOCK_W-1:0] enc_out;
    logic [saes_pkg::BLOCK_W-1:0] dec_r1;
    logic [saes_pkg::BLOCK_W-1:0] dec_out;

    always_comb begin
        enc_r1  = saes_pkg::mix_cols(
                      saes_pkg::shift_row(saes_pkg::sub_nib_fwd(data_block ^ round_keys.k0)),
                      saes_pkg::MIX_DIAG, saes_pkg::MIX_OFF) ^ round_keys.k1;
        enc_out = saes_pkg::shift_row(saes_pkg::sub_nib_fwd(enc_r1)) ^ round_keys.k2;

        dec_r1  = saes_pkg::sub_nib_inv(saes_pkg::shift_row(data_block ^ round_keys.k2))
                  ^ round_keys.k1;
        dec_out = saes_pkg::sub_nib_inv(saes_pkg::shift_row(
                      saes_pkg::mix_cols(dec_r1, saes_pkg::INV_MIX_DIAG,
                                         saes_pkg::INV_MIX_OFF))) ^ round_keys.k0;

        result_block = (operation == saes_pkg::OP_DECRYPT) ? dec_out : enc_out;
    end

endmodule

// ===== rtl/simplified_aes_cipher.sv =====
// An input transfer loads the input register; both rounds sit between it and the result
// register, which drives m_valid.
// Throughput: one block per cycle while m_ready does not stall the result register.
// A stalled result register keeps the input register loaded; s_ready drops only when both hold.
// Reset (aresetn low, synchronous): both pipeline stages empty, key set to 0 with its
// round keys already expanded.
`timescale 1ns / 1ps

`include "simplified_aes_cipher_defines.svh"

module simplified_aes_cipher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [saes_pkg::BLOCK_W-1:0]     cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic [saes_pkg::BLOCK_W-1:0]     s_data_block,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [saes_pkg::BLOCK_W-1:0]     m_result_block
);

    saes_pkg::round_keys_t        round_keys;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic                         in_op_reg;
    logic [saes_pkg::BLOCK_W-1:0] in_data_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [saes_pkg::BLOCK_W-1:0] out_result_reg;
    logic [saes_pkg::BLOCK_W-1:0] core_result;
    logic                         out_ready;
    logic                         advance;

    saes_key_sched u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .round_keys (round_keys)
    );

    saes_core u_core (
        .operation    (in_op_reg),
        .data_block   (in_data_reg),
        .round_keys   (round_keys),
        .result_block (core_result)
    );

    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_data_reg <= s_data_block;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_block = out_result_reg;

    `SAES_ASSERT_NOW(a_full_stall_blocks, aclk, aresetn,
                     in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `SAES_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    `SAES_ASSERT_NEXT(a_advance_captures, aclk, aresetn, advance,
                      m_result_block == $past(core_result))

endmodule

// ===== sim/saes_checker.sv =====
`timescale 1ns / 1ps

module saes_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_data_block,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_result_block,
    output int          fail_count,
    output int          pending
);

    // S-boxes packed with entry 0 in bits 3:0
    localparam logic [63:0] ENC_BOX = 64'h7FEC_3026_581D_BA49;
    localparam logic [63:0] DEC_BOX = 64'hED4C_3206_F871_B95A;

    logic [15:0] cur_key = 16'h0000;
    logic [15:0] result_q[$];
    logic [15:0] want;

    function automatic logic [3:0] gf16_product(input logic [3:0] x, input logic [3:0] y);
        logic [3:0] prod;
        logic [3:0] term;
        prod = 4'h0;
        term = x;
        for (int i = 0; i < 4; i++) begin
            if (y[i]) begin
                prod = prod ^ term;
            end
            // multiply by x, fold x^4 back as x + 1
            term = term[3] ? ((term << 1) ^ 4'h3) : (term << 1);
        end
        return prod;
    endfunction

    function automatic logic [15:0] nibble_sub(input logic [15:0] v, input logic [63:0] box);
        logic [15:0] r;
        for (int n = 0; n < 4; n++) begin
            r[n*4 +: 4] = box[v[n*4 +: 4]*4 +: 4];
        end
        return r;
    endfunction

    function automatic logic [15:0] swap_low_nibbles(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        r[11:8] = v[3:0];
        r[3:0]  = v[11:8];
        return r;
    endfunction

    function automatic logic [15:0] column_mix(input logic [15:0] v, input logic [3:0] dg,
                                               input logic [3:0] od);
        logic [15:0] r;
        for (int c = 0; c < 2; c++) begin
            r[c*8+4 +: 4] = gf16_product(dg, v[c*8+4 +: 4]) ^ gf16_product(od, v[c*8 +: 4]);
            r[c*8 +: 4]   = gf16_product(od, v[c*8+4 +: 4]) ^ gf16_product(dg, v[c*8 +: 4]);
        end
        return r;
    endfunction

    function automatic logic [7:0] key_word_mix(input logic [7:0] w);
        logic [7:0] rot;
        rot = {w[3:0], w[7:4]};
        return {ENC_BOX[rot[7:4]*4 +: 4], ENC_BOX[rot[3:0]*4 +: 4]};
    endfunction

    function automatic logic [15:0] saes_transform(input logic op, input logic [15:0] blk,
                                                   input logic [15:0] key);
        logic [7:0]  w2;
        logic [7:0]  w3;
        logic [7:0]  w4;
        logic [7:0]  w5;
        logic [15:0] rk1;
        logic [15:0] rk2;
        logic [15:0] v;
        w2  = key[15:8] ^ saes_pkg::RCON_ONE ^ key_word_mix(key[7:0]);
        w3  = w2 ^ key[7:0];
        w4  = w2 ^ saes_pkg::RCON_TWO ^ key_word_mix(w3);
        w5  = w4 ^ w3;
        rk1 = {w2, w3};
        rk2 = {w4, w5};
        v   = blk;
        if (op == saes_pkg::OP_ENCRYPT) begin
            v = v ^ key;
            v = column_mix(swap_low_nibbles(nibble_sub(v, ENC_BOX)),
                           saes_pkg::MIX_DIAG, saes_pkg::MIX_OFF) ^ rk1;
            v = swap_low_nibbles(nibble_sub(v, ENC_BOX)) ^ rk2;
        end else begin
            v = v ^ rk2;
            v = nibble_sub(swap_low_nibbles(v), DEC_BOX) ^ rk1;
            v = column_mix(v, saes_pkg::INV_MIX_DIAG, saes_pkg::INV_MIX_OFF);
            v = nibble_sub(swap_low_nibbles(v), DEC_BOX) ^ key;
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_key = 16'h0000;
            result_q.delete();
        end else begin
            // compare first so a result can never match an item taken at the same edge
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result_block: no transfer expected, actual %h", m_result_block);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (m_result_block !== want) begin
                        $error("result_block: expected %h, actual %h", want, m_result_block);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                result_q.push_back(saes_transform(s_operation, s_data_block, cur_key));
            end
            if (cfg_we) begin
                cur_key = cfg_wdata;
            end
        end
        pending = result_q.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = saes_pkg::OP_ENCRYPT;
    logic [15:0] s_data_block = 16'h0000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_result_block;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    simplified_aes_cipher DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_block   (s_data_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_block (m_result_block)
    );

    saes_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_block   (s_data_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_block (m_result_block),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold valid and payload until the transfer; drop valid only on a gap.
    task automatic send_block(input logic op, input logic [15:0] blk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_operation  = op;
        s_data_block = blk;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_key(input logic [15:0] key);
        cfg_we    = 1'b1;
        cfg_wdata = key;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_random_blocks(input int count);
        logic        op;
        logic [15:0] blk;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(1) ? saes_pkg::OP_DECRYPT : saes_pkg::OP_ENCRYPT;
            case ($urandom_range(9))
                0: blk = 16'h0000;
                1: blk = 16'hFFFF;
                default: blk = 16'($urandom_range(16'hFFFF));
            endcase
            send_block(op, blk);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset key, extremes of the block
        send_block(saes_pkg::OP_ENCRYPT, 16'h0000);
        send_block(saes_pkg::OP_DECRYPT, 16'h0000);
        send_block(saes_pkg::OP_ENCRYPT, 16'hFFFF);
        send_block(saes_pkg::OP_DECRYPT, 16'hFFFF);
        drain_results();

        // textbook key and block pair, then alternating and single-bit patterns
        load_key(16'hA73B);
        send_block(saes_pkg::OP_ENCRYPT, 16'h6F6B);
        send_block(saes_pkg::OP_DECRYPT, 16'h0738);
        send_block(saes_pkg::OP_ENCRYPT, 16'h5555);
        send_block(saes_pkg::OP_DECRYPT, 16'hAAAA);
        send_block(saes_pkg::OP_ENCRYPT, 16'h8000);
        send_block(saes_pkg::OP_DECRYPT, 16'h0001);
        send_block(saes_pkg::OP_ENCRYPT, 16'h0000);
        send_block(saes_pkg::OP_DECRYPT, 16'hFFFF);
        drain_results();

        load_key(16'hFFFF);
        send_block(saes_pkg::OP_ENCRYPT, 16'h0000);
        send_block(saes_pkg::OP_ENCRYPT, 16'hFFFF);
        send_block(saes_pkg::OP_DECRYPT, 16'h0000);
        send_block(saes_pkg::OP_DECRYPT, 16'hFFFF);
        send_block(saes_pkg::OP_ENCRYPT, 16'h1234);
        send_block(saes_pkg::OP_DECRYPT, 16'hFEDC);
        drain_results();

        // three idle modes, two key settings each
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct   = 14;
                    recv_stall_pct = 46;
                end
                1: begin
                    send_gap_pct   = 46;
                    recv_stall_pct = 14;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                drain_results();
                if (mode == 0 && seg == 0) begin
                    load_key(16'h0000);
                end else if (mode == 1 && seg == 0) begin
                    load_key(16'hFFFF);
                end else begin
                    load_key(16'($urandom_range(16'hFFFF)));
                end
                send_random_blocks(RANDOM_ITEMS / 6);
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/saes_pkg.sv
rtl/saes_key_sched.sv
rtl/saes_core.sv
rtl/simplified_aes_cipher.sv
sim/saes_checker.sv
sim/tb.sv
